[rtl/trapezoid_velocity_profile_defines.svh]
// Assertion macros shared by the trapezoid velocity profile RTL.
`ifndef TRAPEZOID_VELOCITY_PROFILE_DEFINES_SVH
`define TRAPEZOID_VELOCITY_PROFILE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TVP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TVP_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define TVP_ASSERT(name, clk, rst, prop, msg)
`define TVP_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/tvp_pkg.sv]
// Types and constants of the trapezoid velocity profile generator.
package tvp_pkg;

   localparam int POS_W      = 25;
   localparam int MAG_W      = 25;
   localparam int WIN_W      = 16;
   localparam int SCALE_W    = 4;
   localparam int TICK_W     = 20;
   localparam int AEND_W     = TICK_W + 1;
   localparam int ACC_W      = 16;
   localparam int LIM_W      = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int VEL_W      = 26;
   localparam int VOUT_W     = 17;
   localparam int FRAC_W     = 8;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 24;

   localparam int PROD_W     = 2 * TICK_W;
   localparam int MAG125_W   = 32;
   localparam int NUM_SHIFT  = 13;
   localparam int NUM_W      = MAG125_W + NUM_SHIFT;
   localparam int DIFF_W     = NUM_W + 1;
   localparam int SQ_REM_W   = TICK_W + 1;
   localparam int SQ_TRY_W   = SQ_REM_W + 2;
   localparam int DIV_STEPS  = NUM_W;
   localparam int SQRT_STEPS = TICK_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

   localparam logic [TICK_W-1:0] DECEL_RESET = TICK_W'(100000);
   localparam logic [AEND_W-1:0] ACCEL_RESET = '1;

   localparam logic [ACC_W-1:0]   ACCEL_STEP_RESET = ACC_W'(16305);
   localparam logic [LIM_W-1:0]   VEL_LIMIT_RESET  = LIM_W'(21845);
   localparam logic [SCALE_W-1:0] TIME_SCALE_RESET = SCALE_W'(3);

   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEL_STEP = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_VEL_LIMIT  = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_TIME_SCALE = CSR_ADDR_W'(2);

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_PLAN = 1'b1;

   typedef enum logic [2:0] {
      PLAN_IDLE,
      PLAN_DIV,
      PLAN_CMP,
      PLAN_SQRT,
      PLAN_DONE
   } plan_state_type;

   typedef struct packed {
      logic              start;
      logic [TICK_W-1:0] time_ticks;
      logic [MAG_W-1:0]  dist_mag;
      logic [ACC_W-1:0]  accel;
   } plan_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic              err;
      logic [TICK_W-1:0] root;
   } plan_rsp_type;

endpackage

[rtl/tvp_plan.sv]
// Bit-serial plan unit: divide, square and integer square root for one move plan.
`include "trapezoid_velocity_profile_defines.svh"

module tvp_plan (
   input  logic                  clock,
   input  logic                  reset,
   input  tvp_pkg::plan_req_type plan_req,
   input  logic                  plan_ack,
   output tvp_pkg::plan_rsp_type plan_rsp
);
   import tvp_pkg::*;

   plan_state_type state_ff, state_in;

   logic [NUM_W-1:0]    num_ff;
   logic [ACC_W-1:0]    rem_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [PROD_W-1:0]   mcand_ff;
   logic [TICK_W-1:0]   mplier_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                err_ff;
   logic [PROD_W-1:0]   x_ff;
   logic [SQ_REM_W-1:0] sq_rem_ff;
   logic [TICK_W-1:0]   root_ff;

   logic [MAG125_W-1:0] mag_ext;
   logic [MAG125_W-1:0] mag125;
   logic [ACC_W:0]      div_try;
   logic                q_bit;
   logic [ACC_W-1:0]    div_rem_in;
   logic [DIFF_W-1:0]   diff;
   logic                diff_nonpos;
   logic [SQ_TRY_W-1:0] sq_try;
   logic [SQ_TRY_W-1:0] sq_trial;
   logic                sq_bit;

   assign mag_ext = MAG125_W'(plan_req.dist_mag);
   assign mag125  = (mag_ext << 7) - (mag_ext << 1) - mag_ext;

   assign div_try    = {rem_ff, num_ff[NUM_W-1]};
   assign q_bit      = div_try >= {1'b0, acc_ff};
   assign div_rem_in = q_bit ? ACC_W'(div_try - {1'b0, acc_ff}) : div_try[ACC_W-1:0];

   assign diff        = DIFF_W'(prod_ff) - {1'b0, num_ff};
   assign diff_nonpos = diff[DIFF_W-1] || (diff == '0);

   assign sq_try   = {sq_rem_ff, x_ff[PROD_W-1 -: 2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_bit   = sq_try >= sq_trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PLAN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PLAN_IDLE: begin
            if (plan_req.start) state_in = PLAN_DIV;
         end
         PLAN_DIV: begin
            if (cnt_ff == DIV_LAST) state_in = PLAN_CMP;
         end
         PLAN_CMP: begin
            state_in = diff_nonpos ? PLAN_DONE : PLAN_SQRT;
         end
         PLAN_SQRT: begin
            if (cnt_ff == SQRT_LAST) state_in = PLAN_DONE;
         end
         PLAN_DONE: begin
            if (plan_ack) state_in = PLAN_IDLE;
         end
         default: state_in = PLAN_IDLE;
      endcase
   end

   always_comb begin
      plan_rsp.busy = state_ff != PLAN_IDLE;
      plan_rsp.done = state_ff == PLAN_DONE;
      plan_rsp.err  = err_ff;
      plan_rsp.root = root_ff;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         PLAN_IDLE: begin
            if (plan_req.start) begin
               num_ff    <= {mag125, NUM_SHIFT'(0)};
               rem_ff    <= '0;
               acc_ff    <= plan_req.accel;
               mcand_ff  <= PROD_W'(plan_req.time_ticks);
               mplier_ff <= plan_req.time_ticks;
               prod_ff   <= '0;
               cnt_ff    <= '0;
            end
         end
         PLAN_DIV: begin
            num_ff    <= {num_ff[NUM_W-2:0], q_bit};
            rem_ff    <= div_rem_in;
            prod_ff   <= prod_ff + (mplier_ff[0] ? mcand_ff : '0);
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
            cnt_ff    <= cnt_ff + 1'b1;
         end
         PLAN_CMP: begin
            err_ff    <= diff_nonpos;
            x_ff      <= diff[PROD_W-1:0];
            sq_rem_ff <= '0;
            root_ff   <= '0;
            cnt_ff    <= '0;
         end
         PLAN_SQRT: begin
            x_ff      <= x_ff << 2;
            sq_rem_ff <= sq_bit ? SQ_REM_W'(sq_try - sq_trial) : sq_try[SQ_REM_W-1:0];
            root_ff   <= {root_ff[TICK_W-2:0], sq_bit};
            cnt_ff    <= cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   `TVP_ASSERT_IMPL(a_div_rem_below_divisor, clock, reset, state_ff == PLAN_DIV, rem_ff < acc_ff, "division remainder not below divisor")
   `TVP_ASSERT_IMPL(a_div_divisor_nonzero, clock, reset, state_ff == PLAN_DIV, acc_ff != '0, "zero divisor in division")
   `TVP_ASSERT(a_done_after_work, clock, reset, (state_ff == PLAN_DONE) |-> ($past(state_ff) != PLAN_IDLE), "plan finished without work")

endmodule

[rtl/trapezoid_velocity_profile.sv]
// Top level of the single-axis trapezoid velocity profile generator.
//
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  req_tuser cmd, req_tdata plan fields and stop
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata velocity, done and error flags
// csr      in         csr_we                 csr_addr register index, csr_wdata value
//
// A tick's result is registered in the cycle after its transfer.
// A plan runs the bit-serial divider (45 steps, squaring runs beside it), then a compare, and
// when the window is long enough the 20-step square root; a too-short window skips the root.
// Reset is synchronous and restores the register and profile state.
// While a plan runs or the result register is full and stalled, req_tready stays low.

`include "trapezoid_velocity_profile_defines.svh"

module trapezoid_velocity_profile (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // origin_pos[24:0], target_pos[49:25], window_ms[65:50], stop[66], zero fill
   input  logic [tvp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // cmd[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // velocity_cmd[16:0], move_done[17], plan_error[18], zero fill
   output logic [tvp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [tvp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [tvp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tvp_pkg::*;

   logic [ACC_W-1:0]   accel_step_ff;
   logic [LIM_W-1:0]   vel_limit_ff;
   logic [SCALE_W-1:0] time_scale_ff;

   logic [TICK_W-1:0]       tick_count_ff, tick_count_in;
   logic signed [AEND_W-1:0] accel_end_ff, accel_end_in;
   logic [TICK_W-1:0]       decel_start_ff, decel_start_in;
   logic [TICK_W-1:0]       move_end_ff, move_end_in;
   logic signed [VEL_W-1:0] velocity_acc_ff, velocity_acc_in;
   logic signed [1:0]       direction_ff, direction_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VOUT_W-1:0] rsp_vel_ff, rsp_vel_in;
   logic                     rsp_done_ff, rsp_done_in;
   logic                     rsp_err_ff, rsp_err_in;

   plan_req_type plan_req;
   plan_rsp_type plan_rsp;
   logic         plan_ack;

   logic                     req_fire;
   logic                     is_plan;
   logic                     is_tick;
   logic signed [POS_W-1:0]  origin_pos;
   logic signed [POS_W-1:0]  target_pos;
   logic [WIN_W-1:0]         window_ms;
   logic                     stop;
   logic signed [POS_W:0]    travel;
   logic [MAG_W-1:0]         dist_mag;
   logic [TICK_W-1:0]        time_ticks;
   logic [TICK_W:0]          ae_sum;
   logic [TICK_W:0]          ds_sum;

   logic [TICK_W-1:0]        tick_next;
   logic                     in_accel;
   logic                     at_end;
   logic                     in_decel;
   logic signed [VEL_W:0]    step_pos;
   logic signed [VEL_W:0]    step_dir;
   logic signed [VEL_W:0]    delta;
   logic signed [VEL_W:0]    vel_sum;
   logic signed [VEL_W:0]    lim;
   logic signed [VEL_W-1:0]  vel_new;
   logic [VEL_W-1:0]         vel_mag;
   logic [VOUT_W-1:0]        vel_int;

   assign origin_pos = req_tdata[POS_W-1:0];
   assign target_pos = req_tdata[2*POS_W-1:POS_W];
   assign window_ms  = req_tdata[2*POS_W+WIN_W-1:2*POS_W];
   assign stop       = req_tdata[2*POS_W+WIN_W];

   assign req_tready = !plan_rsp.busy && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign is_plan    = req_fire && (req_tuser == CMD_PLAN);
   assign is_tick    = req_fire && (req_tuser == CMD_TICK) && !stop;
   assign plan_ack   = plan_rsp.done && (!rsp_valid_ff || rsp_tready);

   assign travel     = (POS_W+1)'(target_pos) - (POS_W+1)'(origin_pos);
   assign dist_mag   = travel[POS_W] ? MAG_W'(-travel) : travel[MAG_W-1:0];
   assign time_ticks = TICK_W'(window_ms) * TICK_W'(time_scale_ff);

   assign plan_req.start      = is_plan;
   assign plan_req.time_ticks = time_ticks;
   assign plan_req.dist_mag   = dist_mag;
   assign plan_req.accel      = (accel_step_ff == '0) ? ACC_W'(1) : accel_step_ff;

   tvp_plan u_plan (
      .clock    (clock),
      .reset    (reset),
      .plan_req (plan_req),
      .plan_ack (plan_ack),
      .plan_rsp (plan_rsp)
   );

   assign ae_sum = {1'b0, move_end_ff} - {1'b0, plan_rsp.root};
   assign ds_sum = {1'b0, move_end_ff} + {1'b0, plan_rsp.root};

   assign tick_next = tick_count_ff + 1'b1;
   assign in_accel  = $signed({1'b0, tick_next}) < accel_end_ff;
   assign at_end    = tick_next >= move_end_ff;
   assign in_decel  = tick_next >= decel_start_ff;
   assign lim       = $signed({3'b000, vel_limit_ff, FRAC_W'(0)});
   assign step_pos  = $signed((VEL_W+1)'(accel_step_ff));

   always_comb begin
      if (direction_ff == 2'sd1) begin
         step_dir = step_pos;
      end else if (direction_ff == -2'sd1) begin
         step_dir = -step_pos;
      end else begin
         step_dir = '0;
      end
      if (in_accel) begin
         delta = step_dir;
      end else if (in_decel) begin
         delta = -step_dir;
      end else begin
         delta = '0;
      end
      vel_sum = {velocity_acc_ff[VEL_W-1], velocity_acc_ff} + delta;
      if (!in_accel && at_end) begin
         vel_sum = '0;
      end
      if (vel_sum > lim) begin
         vel_new = VEL_W'(lim);
      end else if (vel_sum < -lim) begin
         vel_new = VEL_W'(-lim);
      end else begin
         vel_new = VEL_W'(vel_sum);
      end
      vel_mag = vel_new[VEL_W-1] ? VEL_W'(-vel_new) : vel_new;
      vel_int = vel_mag[VOUT_W+FRAC_W-1:FRAC_W];
   end

   always_comb begin
      tick_count_in   = tick_count_ff;
      accel_end_in    = accel_end_ff;
      decel_start_in  = decel_start_ff;
      move_end_in     = move_end_ff;
      velocity_acc_in = velocity_acc_ff;
      direction_in    = direction_ff;
      if (is_plan) begin
         move_end_in  = time_ticks;
         direction_in = travel[POS_W] ? -2'sd1 : ((travel != '0) ? 2'sd1 : 2'sd0);
      end
      if (plan_ack && !plan_rsp.err) begin
         accel_end_in   = $signed({1'b0, ae_sum[TICK_W:1]});
         decel_start_in = ds_sum[TICK_W:1];
      end
      if (is_tick) begin
         velocity_acc_in = vel_new;
         if (!in_accel && at_end) begin
            tick_count_in  = '0;
            accel_end_in   = ACCEL_RESET;
            decel_start_in = DECEL_RESET;
         end else begin
            tick_count_in = tick_next;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (plan_ack) begin
         rsp_valid_in = 1'b1;
         rsp_vel_in   = '0;
         rsp_done_in  = 1'b0;
         rsp_err_in   = plan_rsp.err;
      end else if (req_fire && (req_tuser == CMD_TICK)) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = 1'b0;
         if (stop) begin
            rsp_vel_in  = '0;
            rsp_done_in = 1'b0;
         end else begin
            rsp_vel_in  = vel_new[VEL_W-1] ? $signed(-vel_int) : $signed(vel_int);
            rsp_done_in = !in_accel && at_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_step_ff   <= ACCEL_STEP_RESET;
         vel_limit_ff    <= VEL_LIMIT_RESET;
         time_scale_ff   <= TIME_SCALE_RESET;
         tick_count_ff   <= '0;
         accel_end_ff    <= ACCEL_RESET;
         decel_start_ff  <= DECEL_RESET;
         move_end_ff     <= '0;
         velocity_acc_ff <= '0;
         direction_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_ACCEL_STEP: accel_step_ff <= csr_wdata[ACC_W-1:0];
               CSR_VEL_LIMIT:  vel_limit_ff  <= csr_wdata[LIM_W-1:0];
               CSR_TIME_SCALE: time_scale_ff <= csr_wdata[SCALE_W-1:0];
               default: ;
            endcase
         end
         tick_count_ff   <= tick_count_in;
         accel_end_ff    <= accel_end_in;
         decel_start_ff  <= decel_start_in;
         move_end_ff     <= move_end_in;
         velocity_acc_ff <= velocity_acc_in;
         direction_ff    <= direction_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_vel_ff  <= rsp_vel_in;
      rsp_done_ff <= rsp_done_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_err_ff, rsp_done_ff, rsp_vel_ff});

   `TVP_ASSERT_IMPL(a_done_clears_count, clock, reset, rsp_valid_ff && rsp_done_ff, tick_count_ff == '0, "move done reported with a running tick count")
   `TVP_ASSERT(a_phase_order, clock, reset, accel_end_ff <= $signed({1'b0, decel_start_ff}), "acceleration ends after deceleration starts")
   `TVP_ASSERT_IMPL(a_no_transfer_while_planning, clock, reset, plan_rsp.busy, !req_tready, "input transfer possible during a plan")

endmodule

[test/trapezoid_velocity_profile_checker.sv]
// Checker that predicts and compares every result of the trapezoid velocity profile generator.
module trapezoid_velocity_profile_checker
   import tvp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [VOUT_W-1:0] velocity;
      logic                     done;
      logic                     error;
   } motion_result_t;

   logic [ACC_W-1:0]   accel_step;
   logic [LIM_W-1:0]   vel_limit;
   logic [SCALE_W-1:0] time_scale;

   logic [TICK_W-1:0]  tick_cnt;
   logic [TICK_W-1:0]  decel_mark;
   logic [TICK_W-1:0]  end_mark;
   int                 accel_mark;
   int                 vel_acc;
   int                 heading;

   motion_result_t     expected_motion[$];

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned rest;
      longint unsigned bitv;
      longint unsigned root;
      rest = x;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rest)
         bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rest >= root + bitv) begin
            rest = rest - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic motion_result_t advance_profile(logic cmd, logic [REQ_TDATA_W-1:0] data);
      motion_result_t  res;
      logic signed [POS_W-1:0] start_raw;
      logic signed [POS_W-1:0] goal_raw;
      longint          travel;
      longint          mag;
      longint          span;
      longint          divisor;
      longint          disc;
      longint          root;
      longint          v;
      longint          lim;
      longint          step;
      longint          whole;
      res.velocity = '0;
      res.done     = 1'b0;
      res.error    = 1'b0;
      if (cmd == CMD_PLAN) begin
         start_raw = data[POS_W-1:0];
         goal_raw  = data[2*POS_W-1:POS_W];
         travel    = longint'(goal_raw) - longint'(start_raw);
         mag       = (travel < 0) ? -travel : travel;
         divisor   = (accel_step == 0) ? 64'sd1 : longint'(accel_step);
         span      = longint'(data[2*POS_W+WIN_W-1:2*POS_W]) * longint'(time_scale);
         disc      = span * span - (64'sd1024000 * mag) / divisor;
         heading   = (travel > 0) ? 1 : ((travel < 0) ? -1 : 0);
         end_mark  = span[TICK_W-1:0];
         if (disc > 0) begin
            root       = longint'(int_sqrt(disc));
            accel_mark = int'((span - root) / 2);
            decel_mark = TICK_W'((span + root) / 2);
         end
         res.error = (disc <= 0);
      end else if (!data[2*POS_W+WIN_W]) begin
         v    = vel_acc;
         lim  = longint'(vel_limit) * 256;
         step = longint'(accel_step) * heading;
         tick_cnt = tick_cnt + 1'b1;
         if (int'(tick_cnt) < accel_mark) begin
            v = v + step;
         end else if (tick_cnt >= end_mark) begin
            v          = 0;
            accel_mark = -1;
            decel_mark = DECEL_RESET;
            tick_cnt   = '0;
            res.done   = 1'b1;
         end else if (tick_cnt >= decel_mark) begin
            v = v - step;
         end
         if (v > lim)
            v = lim;
         if (v < -lim)
            v = -lim;
         vel_acc = int'(v);
         whole = (v < 0) ? -((-v) >>> FRAC_W) : (v >>> FRAC_W);
         res.velocity = whole[VOUT_W-1:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      motion_result_t seen;
      motion_result_t want;
      if (reset) begin
         accel_step = ACCEL_STEP_RESET;
         vel_limit  = VEL_LIMIT_RESET;
         time_scale = TIME_SCALE_RESET;
         tick_cnt   = '0;
         accel_mark = -1;
         decel_mark = DECEL_RESET;
         end_mark   = '0;
         vel_acc    = 0;
         heading    = 0;
         expected_motion.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.velocity = rsp_tdata[VOUT_W-1:0];
            seen.done     = rsp_tdata[VOUT_W];
            seen.error    = rsp_tdata[VOUT_W+1];
            if (expected_motion.size() == 0) begin
               $error("Result transfer with no request pending: velocity_cmd %0d", seen.velocity);
               fail_count++;
            end else begin
               want = expected_motion.pop_front();
               if (seen.velocity !== want.velocity) begin
                  $error("velocity_cmd: expected %0d, got %0d", want.velocity, seen.velocity);
                  fail_count++;
               end
               if (seen.done !== want.done) begin
                  $error("move_done: expected %0d, got %0d", want.done, seen.done);
                  fail_count++;
               end
               if (seen.error !== want.error) begin
                  $error("plan_error: expected %0d, got %0d", want.error, seen.error);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_motion.push_back(advance_profile(req_tuser, req_tdata));
         if (csr_we) begin
            case (csr_addr)
               CSR_ACCEL_STEP: accel_step = csr_wdata[ACC_W-1:0];
               CSR_VEL_LIMIT:  vel_limit  = csr_wdata[LIM_W-1:0];
               CSR_TIME_SCALE: time_scale = csr_wdata[SCALE_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_motion.size();
   end

endmodule

[test/trapezoid_velocity_profile_tb.sv]
// Stimulus and verdict for the trapezoid velocity profile generator.
module trapezoid_velocity_profile_tb
   import tvp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES     = 6;
   localparam int PHASE_LEN  = 315;
   localparam longint POS_HI = 16777215;
   localparam longint POS_LO = -16777216;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     outstanding;

   int                     items_sent;
   bit                     calm;
   int unsigned            cur_accel;
   int unsigned            cur_scale;

   trapezoid_velocity_profile DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   trapezoid_velocity_profile_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Entered and left at a falling edge.
   task automatic push_cmd(input logic cmd, input logic [POS_W-1:0] origin_pos,
                           input logic [POS_W-1:0] target_pos, input logic [WIN_W-1:0] window,
                           input logic stop);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, stop, window, target_pos, origin_pos};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_tick(input logic stop);
      push_cmd(CMD_TICK, POS_W'($urandom), POS_W'($urandom), WIN_W'($urandom), stop);
   endtask

   task automatic write_regs(input int unsigned accel, input int unsigned limit,
                             input int unsigned scale);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_ACCEL_STEP;
      csr_wdata <= CSR_DATA_W'(accel);
      @(negedge clock);
      csr_addr  <= CSR_VEL_LIMIT;
      csr_wdata <= CSR_DATA_W'(limit);
      @(negedge clock);
      csr_addr  <= CSR_TIME_SCALE;
      csr_wdata <= CSR_DATA_W'(scale);
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_accel = accel;
      cur_scale = scale;
   endtask

   // A plan whose distance mostly fits the window, followed by the ticks of the move (only some when truncated).
   task automatic run_move(input bit truncate);
      int unsigned win_top;
      int unsigned win;
      int unsigned span;
      int unsigned ticks;
      int unsigned n;
      longint      acc_eff;
      longint      room;
      longint      mag;
      longint      start_p;
      longint      goal_p;
      logic signed [POS_W-1:0] raw;
      logic        stop;
      win_top = (cur_scale == 0) ? 40 : 120 / cur_scale;
      if (win_top < 1)
         win_top = 1;
      win     = $urandom_range(1, win_top);
      span    = win * cur_scale;
      acc_eff = (cur_accel == 0) ? 1 : longint'(cur_accel);
      room    = (longint'(span) * span * acc_eff) / 1024000;
      mag     = longint'($urandom_range(0, int'(room + room / 8 + 1)));
      raw     = POS_W'($urandom);
      start_p = longint'(raw);
      goal_p  = $urandom_range(0, 1) ? start_p + mag : start_p - mag;
      if (goal_p > POS_HI || goal_p < POS_LO)
         goal_p = 2 * start_p - goal_p;
      push_cmd(CMD_PLAN, start_p[POS_W-1:0], goal_p[POS_W-1:0], WIN_W'(win),
               $urandom_range(0, 1) == 1);
      ticks = truncate ? $urandom_range(0, span) : span + $urandom_range(0, 3);
      n = 0;
      while (n < ticks) begin
         stop = ($urandom_range(0, 9) == 0);
         send_tick(stop);
         if (!stop)
            n++;
      end
   endtask

   task automatic run_noise();
      int count;
      if ($urandom_range(0, 1)) begin
         push_cmd(CMD_PLAN, POS_W'($urandom), POS_W'($urandom), WIN_W'($urandom),
                  $urandom_range(0, 1) == 1);
         count = $urandom_range(0, 5);
      end else begin
         count = $urandom_range(1, 6);
      end
      repeat (count)
         send_tick($urandom_range(0, 9) < 3);
   endtask

   initial begin
      int unsigned set_accel[PHASES];
      int unsigned set_limit[PHASES];
      int unsigned set_scale[PHASES];
      int          waited;
      set_accel  = '{16305, 65535, 1, 0, 0, 40000};
      set_limit  = '{21845, 65535, 0, 100, 0, 150};
      set_scale  = '{3, 8, 1, 0, 0, 2};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_TICK;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = CSR_ACCEL_STEP;
      csr_wdata  = '0;
      items_sent = 0;
      calm       = 1'b0;
      cur_accel  = 32'(ACCEL_STEP_RESET);
      cur_scale  = 32'(TIME_SCALE_RESET);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_tick(1'b0);
      send_tick(1'b1);
      push_cmd(CMD_PLAN, 25'h1000000, 25'h0FFFFFF, 16'hFFFF, 1'b1);
      repeat (2) send_tick(1'b0);
      push_cmd(CMD_PLAN, 25'h0FFFFFF, 25'h1000000, 16'h0000, 1'b0);
      push_cmd(CMD_PLAN, 25'd0, 25'd0, 16'hFFFF, 1'b0);
      repeat (2) send_tick(1'b0);
      push_cmd(CMD_PLAN, 25'd0, 25'd1000000, 16'd1, 1'b0);
      push_cmd(CMD_PLAN, 25'd5, 25'd3, 16'd4, 1'b0);
      for (int i = 0; i < 13; i++)
         send_tick(i == 5);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            if (p == 4)
               write_regs($urandom_range(1, 65535), $urandom_range(0, 65535),
                          $urandom_range(1, 15));
            else
               write_regs(set_accel[p], set_limit[p], set_scale[p]);
         end
         while (items_sent < (p + 1) * PHASE_LEN) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 99) < 80)
               run_move($urandom_range(0, 4) == 0);
            else
               run_noise();
         end
         // Leave the phase mid-move so that the next limit meets a live velocity.
         run_move(1'b1);
         req_tvalid <= 1'b0;
         @(negedge clock);
         while (outstanding != 0)
            @(negedge clock);
      end

      waited = 0;
      while (outstanding != 0 && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      repeat (100) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      int hold;
      int stall;
      int r;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_tready <= 1'b1;
         hold = $urandom_range(1, 60);
         repeat (hold) @(negedge clock);
         r = $urandom_range(0, 99);
         if (r < 30)
            stall = 0;
         else if (r < 92)
            stall = $urandom_range(1, 3);
         else
            stall = $urandom_range(10, 40);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

endmodule

[files.f]
+incdir+rtl
rtl/tvp_pkg.sv
rtl/tvp_plan.sv
rtl/trapezoid_velocity_profile.sv
test/trapezoid_velocity_profile_checker.sv
test/trapezoid_velocity_profile_tb.sv
